// File: rtl/core/cfq_pkg.sv
`default_nettype none
package cfq_pkg;

    localparam int QLEN_W     = 5;
    localparam int REQ_W      = 2;
    localparam int ST_W       = 2;
    localparam int RESULT_CAP = 16;
    localparam int CNT_W      = $clog2(RESULT_CAP);

    localparam logic [QLEN_W-1:0] QLEN_RESET = 5'd16;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic            last;
    } t_res_ctl;

endpackage
`default_nettype wire

// File: rtl/core/cfq_ifs.sv
`default_nettype none
interface cfq_in_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                           valid;
    logic                           ready;
    logic [cfq_pkg::REQ_W-1:0]      req_type;
    logic signed [DATA_WIDTH-1:0]   push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface cfq_out_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                           valid;
    logic                           ready;
    logic signed [DATA_WIDTH-1:0]   data_value;
    logic [cfq_pkg::ST_W-1:0]       status_code;
    logic                           last_of_run;

    modport source (output valid, output data_value, output status_code,
                    output last_of_run, input ready);
    modport sink   (input valid, input data_value, input status_code,
                    input last_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cfq_ram.sv
`default_nettype none
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/cfq_out_reg.sv
`default_nettype none
module cfq_out_reg #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [DATA_WIDTH-1:0] i_data,
    input  wire cfq_pkg::t_res_ctl     i_ctl,
    cfq_out_if.source                  o_rsp
);
    import cfq_pkg::*;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_data;
    t_res_ctl              r_ctl;

    assign o_ready = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
            r_ctl  <= i_ctl;
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.data_value  = r_data;
    assign o_rsp.status_code = r_ctl.status;
    assign o_rsp.last_of_run = r_ctl.last;

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_rsp.ready) |-> !o_ready)
        else $error("output register overwritten while held");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_rsp.ready) |=> (r_valid && $stable(r_data)))
        else $error("held result lost");
    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_rsp.ready && !i_valid) |=> !r_valid)
        else $error("taken result repeated");
endmodule
`default_nettype wire

// File: rtl/core/cfq_ctrl.sv
`default_nettype none
module cfq_ctrl #(
    parameter int MAX_DEPTH  = 16,
    parameter int DATA_WIDTH = 32,
    localparam int IW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
    localparam int LW    = ($clog2(MAX_DEPTH + 1) > cfq_pkg::QLEN_W) ?
                           $clog2(MAX_DEPTH + 1) : cfq_pkg::QLEN_W,
    localparam int CMP_W = (LW > cfq_pkg::CNT_W + 1) ? LW : cfq_pkg::CNT_W + 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [LW-1:0]         i_len,
    input  wire logic                  i_cfg_we,
    cfq_in_if.sink                     i_req,
    output logic                       o_res_valid,
    input  wire logic                  i_res_ready,
    output logic [DATA_WIDTH-1:0]      o_res_data,
    output cfq_pkg::t_res_ctl          o_res_ctl,
    output logic                       o_mem_we,
    output logic [IW-1:0]              o_mem_waddr,
    output logic [DATA_WIDTH-1:0]      o_mem_wdata,
    output logic                       o_mem_re,
    output logic [IW-1:0]              o_mem_raddr,
    input  wire logic [DATA_WIDTH-1:0] i_mem_rdata
);
    import cfq_pkg::*;

    function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] idx,
                                                input logic [LW-1:0] len);
        logic [LW:0] s;
        s = (LW + 1)'(idx) + 1'b1;
        return (s >= {1'b0, len}) ? '0 : s[IW-1:0];
    endfunction

    t_state          r_state, n_state;
    logic [IW-1:0]   r_head, n_head;
    logic [IW-1:0]   r_tail, n_tail;
    logic            r_empty, n_empty;
    logic            r_dump, n_dump;
    logic [IW-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0] r_k, n_k;
    logic [ST_W-1:0] r_status, n_status;
    logic            r_use_mem, n_use_mem;

    logic            accept;
    logic            fin;
    logic [CMP_W-1:0] k_next;
    logic [IW-1:0]   tail_nx;
    logic [IW-1:0]   head_nx;
    logic [IW-1:0]   idx_nx;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign tail_nx     = wrap_next(r_tail, i_len);
    assign head_nx     = wrap_next(r_head, i_len);
    assign idx_nx      = wrap_next(r_idx, i_len);
    assign k_next      = CMP_W'(r_k) + 1'b1;
    assign fin         = (r_idx == r_tail) || (k_next >= CMP_W'(i_len))
                         || (k_next >= CMP_W'(RESULT_CAP));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_req.req_type inside {REQ_INSERT, REQ_DELETE, REQ_DUMP})) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_res_ready && (!r_dump || fin)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_empty     = r_empty;
        n_dump      = r_dump;
        n_idx       = r_idx;
        n_k         = r_k;
        n_status    = r_status;
        n_use_mem   = r_use_mem;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_tail;
        o_mem_wdata = i_req.push_value;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_head;
        if (i_cfg_we) begin
            n_head  = '0;
            n_tail  = '0;
            n_empty = 1'b1;
        end else if (accept) begin
            n_dump    = 1'b0;
            n_use_mem = 1'b0;
            n_status  = ST_OK;
            case (i_req.req_type)
                REQ_INSERT: begin
                    if (r_empty) begin
                        n_head      = '0;
                        n_tail      = '0;
                        n_empty     = 1'b0;
                        o_mem_we    = 1'b1;
                        o_mem_waddr = '0;
                    end else if (tail_nx == r_head) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_tail      = tail_nx;
                        o_mem_we    = 1'b1;
                        o_mem_waddr = tail_nx;
                    end
                end
                REQ_DELETE: begin
                    if (r_empty) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        o_mem_re  = 1'b1;
                        n_use_mem = 1'b1;
                        if (r_head == r_tail) begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_empty = 1'b1;
                        end else begin
                            n_head = head_nx;
                        end
                    end
                end
                REQ_DUMP: begin
                    if (r_empty) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        o_mem_re  = 1'b1;
                        n_use_mem = 1'b1;
                        n_dump    = 1'b1;
                        n_idx     = r_head;
                        n_k       = '0;
                    end
                end
                default: n_dump = 1'b0;
            endcase
        end else if (r_state == S_RESP && i_res_ready && r_dump && !fin) begin
            o_mem_re    = 1'b1;
            o_mem_raddr = idx_nx;
            n_idx       = idx_nx;
            n_k         = k_next[CNT_W-1:0];
        end
    end

    always_comb begin
        o_res_valid      = (r_state == S_RESP);
        o_res_data       = r_use_mem ? i_mem_rdata : '0;
        o_res_ctl.status = r_status;
        o_res_ctl.last   = r_dump ? fin : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_dump  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            r_dump  <= n_dump;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_k       <= n_k;
        r_status  <= n_status;
        r_use_mem <= n_use_mem;
    end

    a_empty_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == '0 && r_tail == '0))
        else $error("empty queue with nonzero indices");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LW'(r_head) < i_len) && (LW'(r_tail) < i_len))
        else $error("index beyond queue length");
    a_no_write_in_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) |-> !o_mem_we)
        else $error("memory write while a result is pending");
    a_dump_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_dump) |-> !r_empty)
        else $error("dump walking an empty queue");
endmodule
`default_nettype wire

// File: rtl/core/circular_fifo_queue.sv
// Ring-buffer FIFO of signed words held in one single-port-write, registered-read
// RAM. A request is taken only while no earlier one is in flight; its result goes
// to an output register, so the next request can enter while that result waits.
// Insert and delete requests access the RAM when taken, unless only a status is
// returned; each result then goes to the output register once it is free. A dump
// reads the RAM once per held entry, at most 16 entries per dump. Writing the
// length register (0 acts as 1, above MAX_DEPTH acts as MAX_DEPTH) empties the
// queue; write it only while the block is idle.
`default_nettype none
module circular_fifo_queue #(
    parameter int MAX_DEPTH  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [cfq_pkg::QLEN_W-1:0] i_cfg_wdata,
    cfq_in_if.sink                          i_req,
    cfq_out_if.source                       o_rsp
);
    import cfq_pkg::*;

    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int LW = ($clog2(MAX_DEPTH + 1) > QLEN_W) ? $clog2(MAX_DEPTH + 1) : QLEN_W;

    logic [QLEN_W-1:0]     r_qlen;
    logic [LW-1:0]         eff_len;
    logic [LW-1:0]         qlen_ext;

    logic                  res_valid;
    logic                  res_ready;
    logic [DATA_WIDTH-1:0] res_data;
    t_res_ctl              res_ctl;

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [IW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= QLEN_RESET;
        end else if (i_cfg_we) begin
            r_qlen <= i_cfg_wdata;
        end
    end

    assign qlen_ext = LW'(r_qlen);

    always_comb begin
        if (qlen_ext == '0) begin
            eff_len = LW'(1);
        end else if (qlen_ext > LW'(MAX_DEPTH)) begin
            eff_len = LW'(MAX_DEPTH);
        end else begin
            eff_len = qlen_ext;
        end
    end

    cfq_ctrl #(
        .MAX_DEPTH  (MAX_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_len       (eff_len),
        .i_cfg_we    (i_cfg_we),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_data  (res_data),
        .o_res_ctl   (res_ctl),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    cfq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cfq_out_reg #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_data  (res_data),
        .i_ctl   (res_ctl),
        .o_rsp   (o_rsp)
    );
endmodule
`default_nettype wire
